FILE: rtl/core/pbac_pkg.sv
// Shared widths, register codes, palette tables and result type for the
// pixel block to ASCII character block. No dependencies.
`timescale 1ns / 1ps

package pbac_pkg;

  // Default limits of the top level parameters, and the fixed height limit.
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_BLOCK = 64;
  localparam int MAX_HEIGHT    = 4096;

  // Field and datapath widths.
  localparam int CHAN_W  = 8;
  localparam int SUM_W   = 10;
  localparam int GREY_W  = 8;
  localparam int CHAR_W  = 8;
  localparam int CNT_W   = 13;
  localparam int DEN_W   = CNT_W + 1;
  localparam int PROD_W  = CNT_W + GREY_W;
  localparam int NUM_W   = PROD_W + 1;
  localparam int QSTEP_W = $clog2(GREY_W);
  localparam int ROW_W   = 12;

  // Configuration port.
  localparam int WID_REG_W = 11;
  localparam int HGT_REG_W = 13;
  localparam int BLK_REG_W = 7;
  localparam int CFG_W     = 13;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd2;

  localparam logic [WID_REG_W-1:0] RST_WIDTH  = 11'd1024;
  localparam logic [HGT_REG_W-1:0] RST_HEIGHT = 13'd1024;
  localparam logic [BLK_REG_W-1:0] RST_BLOCK  = 7'd6;

  // Division by three: floor(s / 3) == (s * 683) >> 11 for s up to 765.
  localparam int RECIP3       = 683;
  localparam int RECIP3_SHIFT = 11;

  localparam logic [CHAR_W-1:0] NEWLINE = 8'd10;

  // Palette "@%#*+=-:. " and the smallest average that reaches each next
  // entry, i.e. ceil((1020 * k + 255) / 40) for k = 1..9.
  localparam int PAL_LEVELS = 10;
  localparam logic [CHAR_W-1:0] PALETTE [PAL_LEVELS] = '{
    8'h40, 8'h25, 8'h23, 8'h2A, 8'h2B, 8'h3D, 8'h2D, 8'h3A, 8'h2E, 8'h20
  };
  localparam logic [GREY_W-1:0] PAL_STEP [PAL_LEVELS-1] = '{
    8'd32, 8'd58, 8'd83, 8'd109, 8'd134, 8'd160, 8'd185, 8'd211, 8'd236
  };

  typedef struct packed {
    logic [CHAR_W-1:0] symbol;
    logic              last_of_run;
    logic              end_of_image;
  } out_t;

  function automatic logic [CHAR_W-1:0] pal_char(input logic [GREY_W-1:0] avg);
    logic [3:0] idx;
    idx = '0;
    for (int k = 0; k < PAL_LEVELS - 1; k++) begin
      if (avg >= PAL_STEP[k]) idx = idx + 4'd1;
    end
    return PALETTE[idx];
  endfunction

endpackage

FILE: rtl/core/pbac_avg_div.sv
// Iterative divider for the running block average: one quotient bit per cycle.
// Depends on pbac_pkg for the operand widths.
`timescale 1ns / 1ps

module pbac_avg_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pbac_pkg::NUM_W-1:0]  num,
  input  logic [pbac_pkg::DEN_W-1:0]  den,
  output logic                        done,
  output logic [pbac_pkg::GREY_W-1:0] quo
);
  import pbac_pkg::*;

  logic               busy;
  logic [QSTEP_W-1:0] step;
  logic [NUM_W-1:0]   rem;
  logic [NUM_W-1:0]   dsh;
  logic               ge;

  // The quotient of a weighted average never exceeds 255, so eight
  // restoring steps starting at the divisor shifted by seven are exact.
  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
      rem  <= num;
      dsh  <= NUM_W'(den) << (GREY_W - 1);
      quo  <= '0;
    end else if (busy) begin
      if (ge) rem <= rem - dsh;
      quo  <= {quo[GREY_W-2:0], ge};
      dsh  <= dsh >> 1;
      step <= step + QSTEP_W'(1);
      if (step == QSTEP_W'(GREY_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

FILE: rtl/core/pixel_block_to_ascii_char_top.sv
// Pixel block to ASCII character converter: top level with the block column
// store, position tracking, output queue. Depends on pbac_pkg, pbac_avg_div.
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   config  | cfg_we, cfg_index, cfg_data          | in
//   pixel   | in_valid, in_stall, red/green/blue   | in
//   result  | out_valid, out_stall, symbol,        | out
//           | last_of_run, end_of_image            |
//
// A pixel passes from acceptance through the store read, the multiply and the
// 8-step average divider until its results sit in the output queue and the next
// pixel can be taken. The first pixel after a block_size write first runs a
// bit-serial division that finds its block column.
// Reset zeroes the positions; the store is not cleared and needs no pass.
// A two-entry output queue lets a new pixel be accepted while results wait;
// write-back holds only when the queue lacks room for the pixel's results.
`timescale 1ns / 1ps

module pixel_block_to_ascii_char_top #(
  parameter int MAX_WIDTH = pbac_pkg::DEF_MAX_WIDTH,
  parameter int MAX_BLOCK = pbac_pkg::DEF_MAX_BLOCK
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pbac_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [pbac_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pbac_pkg::CHAN_W-1:0]    red,
  input  logic [pbac_pkg::CHAN_W-1:0]    green,
  input  logic [pbac_pkg::CHAN_W-1:0]    blue,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pbac_pkg::CHAR_W-1:0]    symbol,
  output logic                           last_of_run,
  output logic                           end_of_image
);
  import pbac_pkg::*;

  localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int BLK_W   = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int BSZ_W   = $clog2(MAX_BLOCK + 1);
  localparam int SDC_W   = $clog2(COL_W + 1);
  localparam int STORE_W = CNT_W + GREY_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SLOT, S_READ, S_MULT, S_START, S_WAIT, S_WB
  } state_t;

  typedef struct packed {
    logic [COL_W-1:0] q;
    logic [BLK_W-1:0] r;
  } slot_pos_t;

  function automatic logic [COL_W-1:0] clamp_w(input logic [WID_REG_W-1:0] v);
    logic [HGT_REG_W-1:0] t;
    if (v == '0) t = HGT_REG_W'(1);
    else if (HGT_REG_W'(v) > HGT_REG_W'(MAX_WIDTH)) t = HGT_REG_W'(MAX_WIDTH);
    else t = HGT_REG_W'(v);
    return COL_W'(t - HGT_REG_W'(1));
  endfunction

  function automatic logic [ROW_W-1:0] clamp_h(input logic [HGT_REG_W-1:0] v);
    logic [HGT_REG_W-1:0] t;
    if (v == '0) t = HGT_REG_W'(1);
    else if (v > HGT_REG_W'(MAX_HEIGHT)) t = HGT_REG_W'(MAX_HEIGHT);
    else t = v;
    return ROW_W'(t - HGT_REG_W'(1));
  endfunction

  function automatic logic [BSZ_W-1:0] clamp_b(input logic [BLK_REG_W-1:0] v);
    logic [BLK_REG_W:0] t;
    if (v == '0) t = (BLK_REG_W+1)'(1);
    else if ((BLK_REG_W+1)'(v) > (BLK_REG_W+1)'(MAX_BLOCK)) t = (BLK_REG_W+1)'(MAX_BLOCK);
    else t = (BLK_REG_W+1)'(v);
    return BSZ_W'(t);
  endfunction

  // Block column tracking: column_position == q * block_size + r.
  function automatic slot_pos_t slot_adv(input logic [COL_W-1:0] q,
                                         input logic [BLK_W-1:0] r,
                                         input logic             wrap,
                                         input logic [BLK_W-1:0] r_last);
    slot_pos_t p;
    if (wrap) begin
      p.q = '0;
      p.r = '0;
    end else if (r == r_last) begin
      p.q = q + COL_W'(1);
      p.r = '0;
    end else begin
      p.q = q;
      p.r = r + BLK_W'(1);
    end
    return p;
  endfunction

  // Configuration, kept in clamped form.
  logic [COL_W-1:0] w_m1;
  logic [ROW_W-1:0] h_m1;
  logic [BSZ_W-1:0] bs_c;
  logic [BLK_W-1:0] bs_m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_m1 <= clamp_w(RST_WIDTH);
      h_m1 <= clamp_h(RST_HEIGHT);
      bs_c <= clamp_b(RST_BLOCK);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  w_m1 <= clamp_w(cfg_data[WID_REG_W-1:0]);
        REG_IMAGE_HEIGHT: h_m1 <= clamp_h(cfg_data[HGT_REG_W-1:0]);
        REG_BLOCK_SIZE:   bs_c <= clamp_b(cfg_data[BLK_REG_W-1:0]);
        default: ;
      endcase
    end
  end

  assign bs_m1 = BLK_W'(bs_c - BSZ_W'(1));

  // Sequencer state and positions.
  state_t           state;
  logic [COL_W-1:0] col_pos;
  logic [ROW_W-1:0] row_pos;
  logic [BLK_W-1:0] cib;
  logic [BLK_W-1:0] rib;
  logic [COL_W-1:0] slot_q;
  logic [BLK_W-1:0] slot_r;
  logic             slot_dirty;
  logic [COL_W-1:0] slot;

  logic [GREY_W-1:0] grey_r;
  logic              first_r;
  logic              last_col_r;
  logic              last_row_r;
  logic              emit_r;
  logic [PROD_W-1:0] prod_na;
  logic [DEN_W-1:0]  den_r;

  // Bit-serial slot division after a block size change.
  logic [COL_W-1:0] sd_pos;
  logic [BSZ_W-1:0] sd_rem;
  logic [COL_W-1:0] sd_quo;
  logic [SDC_W-1:0] sd_cnt;
  logic [BSZ_W:0]   sd_trial;
  logic             sd_ge;
  logic [BSZ_W-1:0] sd_rem_n;
  logic [COL_W-1:0] sd_quo_n;

  assign sd_trial = {sd_rem, sd_pos[COL_W-1]};
  assign sd_ge    = (sd_trial >= (BSZ_W+1)'(bs_c));
  assign sd_rem_n = sd_ge ? BSZ_W'(sd_trial - (BSZ_W+1)'(bs_c)) : BSZ_W'(sd_trial);
  assign sd_quo_n = COL_W'({sd_quo, sd_ge});

  logic               acc;
  logic               at_last_col;
  logic               at_last_row;
  logic               at_col_end;
  logic               at_row_end;
  logic [SUM_W-1:0]   pix_sum;
  logic [2*SUM_W-1:0] grey_prod;
  logic [GREY_W-1:0]  grey_val;

  assign in_stall    = (state != S_IDLE);
  assign acc         = in_valid && !in_stall;
  assign at_last_col = (col_pos >= w_m1);
  assign at_last_row = (row_pos >= h_m1);
  assign at_col_end  = at_last_col || (cib >= bs_m1);
  assign at_row_end  = at_last_row || (rib >= bs_m1);
  assign pix_sum     = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
  assign grey_prod   = (2*SUM_W)'(pix_sum) * (2*SUM_W)'(RECIP3);
  assign grey_val    = GREY_W'(grey_prod >> RECIP3_SHIFT);

  // Block column store: {count, average} per block column.
  logic [STORE_W-1:0] blk_store [MAX_WIDTH];
  logic [STORE_W-1:0] rd_word;
  logic [CNT_W-1:0]   st_cnt;
  logic [GREY_W-1:0]  st_avg;
  logic               store_we;
  logic [STORE_W-1:0] store_wdata;

  always_ff @(posedge clk) begin
    if (store_we) blk_store[slot] <= store_wdata;
    rd_word <= blk_store[slot];
  end

  assign st_cnt = rd_word[STORE_W-1:GREY_W];
  assign st_avg = rd_word[GREY_W-1:0];

  // Average divider.
  logic              div_start;
  logic              div_done;
  logic [GREY_W-1:0] div_quo;

  assign div_start = (state == S_START);

  pbac_avg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (NUM_W'(prod_na) + NUM_W'(grey_r)),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Output queue.
  out_t       oq [2];
  out_t       oq_n [2];
  logic [1:0] ocnt;
  logic [1:0] ocnt_n;
  logic [1:0] cnt_after;
  logic [1:0] need;
  logic       pop;
  logic       wb_commit;
  out_t       res0;
  out_t       res1;

  assign pop       = out_valid && !out_stall;
  assign cnt_after = ocnt - {1'b0, pop};
  assign need      = emit_r ? (last_col_r ? 2'd2 : 2'd1) : 2'd0;
  assign wb_commit = (state == S_WB) && ({1'b0, cnt_after} + {1'b0, need} <= 3'd2);

  assign res0.symbol       = pal_char(div_quo);
  assign res0.last_of_run  = !last_col_r;
  assign res0.end_of_image = 1'b0;
  assign res1.symbol       = NEWLINE;
  assign res1.last_of_run  = 1'b1;
  assign res1.end_of_image = last_row_r;

  always_comb begin
    oq_n[0] = oq[0];
    oq_n[1] = oq[1];
    if (pop) oq_n[0] = oq[1];
    if (wb_commit && need != 2'd0) begin
      oq_n[cnt_after[0]] = res0;
      if (need == 2'd2) oq_n[1] = res1;
    end
    ocnt_n = cnt_after + (wb_commit ? need : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= '0;
    end else begin
      ocnt <= ocnt_n;
    end
    oq[0] <= oq_n[0];
    oq[1] <= oq_n[1];
  end

  assign out_valid    = (ocnt != 2'd0);
  assign symbol       = oq[0].symbol;
  assign last_of_run  = oq[0].last_of_run;
  assign end_of_image = oq[0].end_of_image;

  assign store_we    = wb_commit;
  assign store_wdata = {den_r[CNT_W-1:0], div_quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      col_pos    <= '0;
      row_pos    <= '0;
      cib        <= '0;
      rib        <= '0;
      slot_q     <= '0;
      slot_r     <= '0;
      slot_dirty <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            grey_r     <= grey_val;
            first_r    <= (rib == '0) && (cib == '0);
            last_col_r <= at_last_col;
            last_row_r <= at_last_row;
            emit_r     <= at_col_end && at_row_end;
            if (at_last_col) begin
              col_pos <= '0;
              cib     <= '0;
              if (at_last_row) begin
                row_pos <= '0;
                rib     <= '0;
              end else begin
                row_pos <= row_pos + ROW_W'(1);
                rib     <= at_row_end ? '0 : rib + BLK_W'(1);
              end
            end else begin
              col_pos <= col_pos + COL_W'(1);
              cib     <= at_col_end ? '0 : cib + BLK_W'(1);
            end
            if (slot_dirty) begin
              sd_pos <= col_pos;
              sd_rem <= '0;
              sd_quo <= '0;
              sd_cnt <= '0;
              state  <= S_SLOT;
            end else begin
              slot             <= slot_q;
              {slot_q, slot_r} <= slot_adv(slot_q, slot_r, at_last_col, bs_m1);
              state            <= S_READ;
            end
          end
        end
        S_SLOT: begin
          sd_rem <= sd_rem_n;
          sd_quo <= sd_quo_n;
          sd_pos <= sd_pos << 1;
          sd_cnt <= sd_cnt + SDC_W'(1);
          if (sd_cnt == SDC_W'(COL_W - 1)) begin
            slot             <= sd_quo_n;
            {slot_q, slot_r} <= slot_adv(sd_quo_n, BLK_W'(sd_rem_n), last_col_r, bs_m1);
            slot_dirty       <= 1'b0;
            state            <= S_READ;
          end
        end
        S_READ: begin
          state <= S_MULT;
        end
        S_MULT: begin
          prod_na <= first_r ? '0 : PROD_W'(st_cnt) * PROD_W'(st_avg);
          den_r   <= first_r ? DEN_W'(1) : DEN_W'(st_cnt) + DEN_W'(1);
          state   <= S_START;
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) state <= S_WB;
        end
        S_WB: begin
          if (wb_commit) state <= S_IDLE;
        end
      endcase
      // A new block size invalidates the tracked block column.
      if (cfg_we && cfg_index == REG_BLOCK_SIZE) slot_dirty <= 1'b1;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    acc |=> (state == S_READ || state == S_SLOT))
    else $error("accepted request did not start the store access");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    ocnt <= 2'd2)
    else $error("output queue overfilled");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_WAIT)
    else $error("divider finished outside the wait state");

  a_slot_rem: assert property (@(posedge clk) disable iff (rst)
    !slot_dirty |-> (BSZ_W'(slot_r) < bs_c))
    else $error("tracked block column remainder out of range");

endmodule

FILE: sim/pixel_block_to_ascii_char_top_test.sv
// Self-checking testbench for pixel_block_to_ascii_char_top: drives pixel requests,
// predicts every palette character and newline, and checks each result in order.
// Depends on pbac_pkg and the RTL of the block.
`timescale 1ns / 1ps

module pixel_block_to_ascii_char_top_test;

  import pbac_pkg::*;

  localparam int STORE_DEPTH   = 1024;
  localparam int BLOCK_LIMIT   = 64;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_IDLE      = 12;
  localparam int MISMATCH_SHOW = 10;

  // Glyphs "@%#*+=-:. " from darkest to lightest.
  localparam logic [CHAR_W-1:0] GLYPHS [10] = '{
    8'h40, 8'h25, 8'h23, 8'h2A, 8'h2B, 8'h3D, 8'h2D, 8'h3A, 8'h2E, 8'h20
  };

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [CHAN_W-1:0]    red;
  logic [CHAN_W-1:0]    green;
  logic [CHAN_W-1:0]    blue;
  logic                 out_valid;
  logic                 out_stall;
  logic [CHAR_W-1:0]    symbol;
  logic                 last_of_run;
  logic                 end_of_image;

  pixel_block_to_ascii_char_top DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .symbol       (symbol),
    .last_of_run  (last_of_run),
    .end_of_image (end_of_image)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the block: registers, per block column stores and positions.
  logic [WID_REG_W-1:0] reg_width;
  logic [HGT_REG_W-1:0] reg_height;
  logic [BLK_REG_W-1:0] reg_block;
  logic [GREY_W-1:0]    shadow_avg [STORE_DEPTH];
  logic [CNT_W-1:0]     shadow_cnt [STORE_DEPTH];
  int unsigned          at_col;
  int unsigned          at_row;
  int unsigned          col_in_blk;
  int unsigned          row_in_blk;

  out_t        pending_symbols [$];
  out_t        got_result;
  out_t        want_result;
  int unsigned error_count;
  int unsigned pixels_sent;
  int unsigned max_gap;
  int unsigned max_stall;
  int unsigned stall_left;
  int unsigned hold_off_left;

  function automatic int unsigned limit_reg(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic int unsigned glyph_level(input int unsigned grey);
    int unsigned idx;
    if (grey < 7) return 0;
    idx = (40 * grey - 255) / 1020;
    return (idx > 9) ? 9 : idx;
  endfunction

  task automatic note_mismatch(input string what, input out_t want, input out_t got);
    error_count++;
    if (error_count <= MISMATCH_SHOW) begin
      $display("%0t: %s: expected symbol=%0d last=%0b eoi=%0b, got symbol=%0d last=%0b eoi=%0b",
               $realtime, what, want.symbol, want.last_of_run, want.end_of_image,
               got.symbol, got.last_of_run, got.end_of_image);
    end
  endtask

  // Folds one accepted pixel into the shadow and queues the results it causes.
  task automatic fold_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int unsigned w, h, bs, grey, slot, n, avg;
    bit last_col, last_row, col_end, row_end;
    out_t item;
    w = limit_reg(reg_width, STORE_DEPTH);
    h = limit_reg(reg_height, MAX_HEIGHT);
    bs = limit_reg(reg_block, BLOCK_LIMIT);
    grey = (r + g + b) / 3;
    slot = (at_col / bs) % STORE_DEPTH;
    last_col = at_col >= w - 1;
    last_row = at_row >= h - 1;
    col_end = last_col || col_in_blk >= bs - 1;
    row_end = last_row || row_in_blk >= bs - 1;
    if (row_in_blk == 0 && col_in_blk == 0) begin
      n = 0;
      avg = 0;
    end else begin
      n = shadow_cnt[slot];
      avg = shadow_avg[slot];
    end
    avg = ((grey + n * avg) / (n + 1)) & 8'hFF;
    n = (n + 1) & 13'h1FFF;
    shadow_avg[slot] = avg[GREY_W-1:0];
    shadow_cnt[slot] = n[CNT_W-1:0];
    if (col_end && row_end) begin
      item.symbol = GLYPHS[glyph_level(avg)];
      item.last_of_run = !last_col;
      item.end_of_image = 1'b0;
      pending_symbols.push_back(item);
      if (last_col) begin
        item.symbol = NEWLINE;
        item.last_of_run = 1'b1;
        item.end_of_image = last_row;
        pending_symbols.push_back(item);
      end
    end
    if (last_col) begin
      at_col = 0;
      col_in_blk = 0;
      if (last_row) begin
        at_row = 0;
        row_in_blk = 0;
      end else begin
        at_row = (at_row + 1) & 12'hFFF;
        row_in_blk = row_end ? 0 : ((row_in_blk + 1) & 6'h3F);
      end
    end else begin
      at_col = (at_col + 1) & 10'h3FF;
      col_in_blk = col_end ? 0 : ((col_in_blk + 1) & 6'h3F);
    end
  endtask

  // Offers one pixel request after a random gap and returns at the edge that takes it.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int unsigned gap;
    gap = $urandom_range(0, max_gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    red <= r;
    green <= g;
    blue <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    fold_pixel(r, g, b);
    pixels_sent++;
  endtask

  // Lowers valid and waits until the block has drained and gone quiet.
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:  reg_width = data[WID_REG_W-1:0];
      REG_IMAGE_HEIGHT: reg_height = data[HGT_REG_W-1:0];
      REG_BLOCK_SIZE:   reg_block = data[BLK_REG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input logic [CFG_W-1:0] bs);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_BLOCK_SIZE, bs);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Most phases idle on both sides; some run without any gaps at all.
  task automatic pick_idle();
    max_gap = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
    max_stall = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
  endtask

  // One full-width row with single-pixel blocks writes every block column entry,
  // so later position changes in the middle of an image never read stale entries.
  task automatic test_store_fill();
    pick_idle();
    configure(STORE_DEPTH, 1, 1);
    repeat (STORE_DEPTH) send_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                                    $urandom_range(0, 255));
    settle_block();
  endtask

  // Single-pixel blocks hit each palette level but '.' (averages 211 to 235), mostly at their lower boundary.
  task automatic test_palette_levels();
    int unsigned greys [12] = '{0, 6, 7, 31, 32, 58, 83, 109, 134, 160, 185, 236};
    pick_idle();
    configure(5, 3, 1);
    foreach (greys[i]) send_pixel(greys[i], greys[i], greys[i]);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd254);
    send_pixel(8'd255, 8'd0, 8'd0);
    settle_block();
  endtask

  // Blocks of three cut by both the right and the bottom edge.
  task automatic test_edge_blocks();
    pick_idle();
    configure(4, 2, 3);
    repeat (8) send_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255));
    settle_block();
  endtask

  // Zero registers act as one: every pixel is a whole image.
  task automatic test_register_clamp();
    pick_idle();
    configure(0, 0, 0);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    settle_block();
  endtask

  // Random images, oversized registers and partial images that leave the
  // positions mid-image for the next setting.
  task automatic test_random_images(input int unsigned pixel_goal);
    int unsigned w, h, bs, count, mode;
    while (pixels_sent < pixel_goal) begin
      pick_idle();
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        w = $urandom_range(1024, 8191);
        h = $urandom_range(4096, 8191);
        bs = $urandom_range(64, 8191);
        count = $urandom_range(40, 120);
      end else if (mode == 1) begin
        w = $urandom_range(0, 3);
        h = $urandom_range(0, 3);
        bs = $urandom_range(0, 4);
        count = (w == 0 ? 1 : w) * (h == 0 ? 1 : h) * $urandom_range(1, 3);
      end else begin
        w = $urandom_range(1, 48);
        h = $urandom_range(1, 16);
        bs = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 64);
        count = (w * h > 300) ? 300 : w * h;
        if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
      end
      configure(w, h, bs);
      repeat (count) send_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                                $urandom_range(0, 255));
      settle_block();
    end
  endtask

  // The receiver holds off while requests keep coming, so the output queue
  // fills and the block has to stall its input.
  task automatic test_backpressure();
    max_gap = 0;
    max_stall = MAX_IDLE;
    configure(6, 8, 1);
    @(posedge clk);
    hold_off_left = 400;
    repeat (48) send_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255));
    settle_block();
  endtask

  // Receiver: stall for a long hold-off if one is pending, else for the
  // cycles drawn after the last result.
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_stall <= 1'b1;
      hold_off_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_result.symbol = symbol;
      got_result.last_of_run = last_of_run;
      got_result.end_of_image = end_of_image;
      if (pending_symbols.size() == 0) begin
        note_mismatch("unexpected result", '0, got_result);
      end else begin
        want_result = pending_symbols.pop_front();
        if (want_result != got_result) note_mismatch("result mismatch", want_result, got_result);
      end
      stall_left = $urandom_range(0, max_stall);
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    red = '0;
    green = '0;
    blue = '0;
    out_stall = 1'b0;
    error_count = 0;
    pixels_sent = 0;
    max_gap = 0;
    max_stall = 0;
    stall_left = 0;
    hold_off_left = 0;
    reg_width = RST_WIDTH;
    reg_height = RST_HEIGHT;
    reg_block = RST_BLOCK;
    at_col = 0;
    at_row = 0;
    col_in_blk = 0;
    row_in_blk = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    test_store_fill();
    test_palette_levels();
    test_edge_blocks();
    test_register_clamp();
    test_random_images(1850);
    test_backpressure();

    if (pending_symbols.size() != 0) begin
      error_count += pending_symbols.size();
      $display("%0d expected results never arrived", pending_symbols.size());
    end
    if (error_count == 0) begin
      $display("pixel_block_to_ascii_char_top_test: clean");
    end else begin
      $display("pixel_block_to_ascii_char_top_test: errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("pixel_block_to_ascii_char_top_test: errors");
    $finish;
  end

endmodule
